// ===== src/kls_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kls_pkg: shared types and constants of the keyword lexer
// Payload structs, controller/datapath command and status, keyword table.
// ---------------------------------------------------------------------------
package kls_pkg;

    localparam int MAX_TEXT_DEF = 16;
    localparam int KW_COUNT     = 6;

    // Token kinds.
    localparam logic [3:0] KIND_LPAREN  = 4'd0;
    localparam logic [3:0] KIND_RPAREN  = 4'd1;
    localparam logic [3:0] KIND_LBRACE  = 4'd2;
    localparam logic [3:0] KIND_RBRACE  = 4'd3;
    localparam logic [3:0] KIND_PLUS    = 4'd4;
    localparam logic [3:0] KIND_STRING  = 4'd5;
    localparam logic [3:0] KIND_KW_BASE = 4'd6;
    localparam logic [3:0] KIND_IDENT   = 4'd12;
    localparam logic [3:0] KIND_ERROR   = 4'd13;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  text_char;
        logic        char_valid;
        logic        token_end;
        logic [15:0] tokens_so_far;
        logic        last;
    } t_out;

    // Which kind of result the datapath puts out this cycle.
    typedef enum logic [1:0] {
        EM_NONE,
        EM_ONE,
        EM_RUN,
        EM_TAIL
    } t_emit;

    typedef struct packed {
        logic  accept;
        t_emit emit;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic run_last;
        logic acc_run;
        logic acc_single;
        logic acc_tail;
        logic plan_tail;
    } t_stat;

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd4, 3'd5, 3'd3, 3'd2, 3'd3};

    // Character p of keyword k; zero past the end of the keyword.
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
        logic [39:0] w;
        unique case (k)
            0:       w = {"func", 8'h00};
            1:       w = {"true", 8'h00};
            2:       w = "false";
            3:       w = {"and", 16'h0000};
            4:       w = {"or", 24'h000000};
            5:       w = {"not", 16'h0000};
            default: w = '0;
        endcase
        if (p > 3'd4) begin
            return 8'h00;
        end
        return w[39 - 8 * int'(p) -: 8];
    endfunction

endpackage
`default_nettype wire

// ===== src/kls_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kls_ctrl: result sequencer of the keyword lexer
// Accepts an item, then walks the results it causes: a word or string
// token (single result or character run) and then any trailing token.
// ---------------------------------------------------------------------------
module kls_ctrl import kls_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_ONE,
        ST_RUN,
        ST_TAIL
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.emit   = EM_NONE;
        o_cmd.last   = 1'b0;
        n_state      = r_state;
        unique case (r_state)
            ST_WAIT: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    if (i_stat.acc_run) begin
                        n_state = i_stat.acc_single ? ST_ONE : ST_RUN;
                    end else if (i_stat.acc_tail) begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_ONE: begin
                o_cmd.emit = EM_ONE;
                o_cmd.last = !i_stat.plan_tail;
                if (i_stat.slot_free) begin
                    n_state = i_stat.plan_tail ? ST_TAIL : ST_WAIT;
                end
            end
            ST_RUN: begin
                o_cmd.emit = EM_RUN;
                o_cmd.last = i_stat.run_last && !i_stat.plan_tail;
                if (i_stat.slot_free && i_stat.run_last) begin
                    n_state = i_stat.plan_tail ? ST_TAIL : ST_WAIT;
                end
            end
            ST_TAIL: begin
                o_cmd.emit = EM_TAIL;
                o_cmd.last = 1'b1;
                if (i_stat.slot_free) begin
                    n_state = ST_WAIT;
                end
            end
            default: n_state = ST_WAIT;
        endcase
    end

    assign o_in_stall = (r_state != ST_WAIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== src/kls_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kls_datapath: lexer state, text buffer and output register
// Classifies the accepted item, updates the lexer mode, buffers word and
// string text, tracks keyword candidates and builds the result items.
// ---------------------------------------------------------------------------
module kls_datapath import kls_pkg::*; #(
    parameter int MAX_TEXT = MAX_TEXT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out      o_out_data
);

    localparam int IW = $clog2(MAX_TEXT);
    localparam int LW = $clog2(MAX_TEXT + 1);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STRING,
        MODE_COMMENT,
        MODE_HALTED
    } t_mode;

    typedef struct packed {
        logic       has_run;
        logic       run_single;
        logic [3:0] run_kind;
        logic       has_tail;
        logic [3:0] tail_kind;
        logic       eot;
    } t_plan;

    t_mode              r_mode, n_mode;
    logic [LW-1:0]      r_len, n_len;
    logic [LW-1:0]      r_run_len;
    logic               r_ovf, n_ovf;
    logic [KW_COUNT-1:0] r_cand, n_cand;
    logic [15:0]        r_count, n_count;
    t_plan              r_plan, n_plan;
    logic [IW-1:0]      r_rd_idx, n_rd_idx;
    logic [7:0]         r_rd_data;
    logic [7:0]         r_mem [MAX_TEXT];
    logic               r_out_valid;
    t_out               r_out, n_out;

    logic [7:0]          c;
    logic                eot;
    logic                is_lower;
    logic [KW_COUNT-1:0] kw_match;
    logic [KW_COUNT-1:0] kw_first;
    logic                kw_hit;
    logic [3:0]          kw_kind;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic                do_idle;
    logic                do_append;
    logic                do_flush;
    logic                slot_free;
    logic                fire;
    logic                run_last;
    logic                tok_start;
    logic [15:0]         count_inc;

    assign c        = i_in_data.char_code;
    assign eot      = i_in_data.end_of_text;
    assign is_lower = (c >= CH_LOW_A) && (c <= CH_LOW_Z);

    // Keyword candidates narrow by one character per appended letter.
    always_comb begin
        kw_hit  = 1'b0;
        kw_kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_match[k] = (r_len < LW'(KW_LEN[k])) && (kw_char(k, r_len[2:0]) == c);
            kw_first[k] = (kw_char(k, 3'd0) == c);
            if (r_cand[k] && (r_len == LW'(KW_LEN[k]))) begin
                kw_hit  = 1'b1;
                kw_kind = KIND_KW_BASE + 4'(k);
            end
        end
    end

    // Lexer step for the item at the input.
    always_comb begin
        n_mode    = r_mode;
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_cand    = r_cand;
        wr_en     = 1'b0;
        wr_addr   = r_len[IW-1:0];
        n_plan    = '0;
        n_plan.run_kind  = KIND_IDENT;
        n_plan.tail_kind = KIND_ERROR;
        do_idle   = 1'b0;
        do_append = 1'b0;
        do_flush  = 1'b0;

        if (eot) begin
            n_plan.eot = 1'b1;
            if (r_mode == MODE_WORD) begin
                do_flush = 1'b1;
            end else if (r_mode == MODE_STRING) begin
                n_plan.has_tail = 1'b1;
            end
            n_mode = MODE_IDLE;
            n_len  = '0;
            n_ovf  = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_HALTED: ;
                MODE_COMMENT: begin
                    if (c == CH_LF) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        n_plan.has_run    = 1'b1;
                        n_plan.run_kind   = KIND_STRING;
                        n_plan.run_single = (r_len == '0);
                        n_mode            = MODE_IDLE;
                        n_len             = '0;
                    end else begin
                        do_append = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_lower) begin
                        do_append = 1'b1;
                    end else begin
                        do_flush = 1'b1;
                        n_mode   = MODE_IDLE;
                        n_len    = '0;
                        do_idle  = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase
        end

        if (do_flush) begin
            n_plan.has_run    = 1'b1;
            n_plan.run_single = kw_hit;
            n_plan.run_kind   = kw_hit ? kw_kind : KIND_IDENT;
        end

        if (do_append) begin
            if (r_len < LW'(MAX_TEXT)) begin
                wr_en  = 1'b1;
                n_len  = r_len + LW'(1);
                n_cand = r_cand & kw_match;
            end else begin
                n_ovf           = 1'b1;
                n_plan.has_tail = 1'b1;
                n_mode          = MODE_HALTED;
            end
        end

        if (do_idle) begin
            unique case (c)
                CH_LPAREN: begin
                    n_plan.has_tail  = 1'b1;
                    n_plan.tail_kind = KIND_LPAREN;
                end
                CH_RPAREN: begin
                    n_plan.has_tail  = 1'b1;
                    n_plan.tail_kind = KIND_RPAREN;
                end
                CH_LBRACE: begin
                    n_plan.has_tail  = 1'b1;
                    n_plan.tail_kind = KIND_LBRACE;
                end
                CH_RBRACE: begin
                    n_plan.has_tail  = 1'b1;
                    n_plan.tail_kind = KIND_RBRACE;
                end
                CH_PLUS: begin
                    n_plan.has_tail  = 1'b1;
                    n_plan.tail_kind = KIND_PLUS;
                end
                CH_QUOTE: begin
                    n_mode = MODE_STRING;
                    n_len  = '0;
                end
                CH_SLASH: n_mode = MODE_COMMENT;
                CH_SPACE, CH_LF, CH_TAB, CH_CR: ;
                default: begin
                    if (is_lower) begin
                        n_mode  = MODE_WORD;
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        n_len   = LW'(1);
                        n_cand  = kw_first;
                    end else begin
                        n_plan.has_tail = 1'b1;
                        n_mode          = MODE_HALTED;
                    end
                end
            endcase
        end
    end

    // Result building.
    assign slot_free = !r_out_valid || !i_out_stall;
    assign fire      = (i_cmd.emit != EM_NONE) && slot_free;
    assign run_last  = ((LW'(r_rd_idx) + LW'(1)) == r_run_len);
    assign tok_start = (i_cmd.emit == EM_ONE) || (i_cmd.emit == EM_TAIL) ||
                       ((i_cmd.emit == EM_RUN) && (r_rd_idx == '0));
    assign count_inc = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;

    always_comb begin
        n_out.text_char     = 8'h00;
        n_out.char_valid    = 1'b0;
        n_out.token_end     = 1'b1;
        n_out.tokens_so_far = tok_start ? count_inc : r_count;
        n_out.last          = i_cmd.last;
        unique case (i_cmd.emit)
            EM_ONE:  n_out.token_kind = r_plan.run_kind;
            EM_RUN: begin
                n_out.token_kind = r_plan.run_kind;
                n_out.text_char  = r_rd_data;
                n_out.char_valid = 1'b1;
                n_out.token_end  = run_last;
            end
            default: n_out.token_kind = r_plan.tail_kind;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.accept && eot && !n_plan.has_run && !n_plan.has_tail) begin
            n_count = '0;
        end else if (fire) begin
            if (i_cmd.last && r_plan.eot) begin
                n_count = '0;
            end else if (tok_start) begin
                n_count = count_inc;
            end
        end
    end

    always_comb begin
        if (i_cmd.emit == EM_RUN) begin
            if (fire) begin
                n_rd_idx = run_last ? '0 : r_rd_idx + IW'(1);
            end else begin
                n_rd_idx = r_rd_idx;
            end
        end else begin
            n_rd_idx = '0;
        end
    end

    // Text buffer with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_mem[wr_addr] <= c;
        end
        r_rd_data <= r_mem[n_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_plan      <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_mode <= n_mode;
                r_len  <= n_len;
                r_ovf  <= n_ovf;
                r_plan <= n_plan;
            end
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cand    <= n_cand;
            r_run_len <= r_len;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_stat.slot_free  = slot_free;
    assign o_stat.run_last   = run_last;
    assign o_stat.acc_run    = n_plan.has_run;
    assign o_stat.acc_single = n_plan.run_single;
    assign o_stat.acc_tail   = n_plan.has_tail;
    assign o_stat.plan_tail  = r_plan.has_tail;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    a_ovf_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_mode == MODE_HALTED))
        else $error("overflow flag set outside the halted mode");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_TEXT))
        else $error("text length beyond buffer size");

    a_char_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.char_valid) |->
        ((r_out.token_kind == KIND_IDENT) || (r_out.token_kind == KIND_STRING)))
        else $error("character carried by a token without text");

endmodule
`default_nettype wire

// ===== src/keyword_lexer_stream.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// keyword_lexer_stream: streaming lexer with keyword recognition
// One source byte or an end-of-text marker per item in; token result
// items out, with identifier and string text as one character per item.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  ------------------------------
//  in       input      i_in_valid / o_in_stall  i_in_data  (char, end marker)
//  out      output     o_out_valid / i_out_stall o_out_data (token fields)
//
// An item that causes no result leaves the sequencer waiting; the next item
// can enter in the following cycle. An item that causes n results, where n
// is at most MAX_TEXT + 1, holds off the input while the single output
// register loads them, one result per cycle when the output does not stall.
// Reset is synchronous and active low; it puts the lexer in its idle mode
// with an empty buffer and a zero token count. A stall on the output holds
// the current result and the sequence behind it; input is refused until
// all results of the current item have been loaded.
//
module keyword_lexer_stream import kls_pkg::*; #(
    parameter int MAX_TEXT = MAX_TEXT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    // Commands from the sequencer and status from the datapath.
    t_cmd  cmd;
    t_stat stat;

    // The sequencer decides, per accepted item, which results go out and
    // in which order: a word or string token first, then any trailing one.
    kls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the lexer mode, the text buffer, the keyword
    // candidates, the token count and the output register.
    kls_datapath #(
        .MAX_TEXT (MAX_TEXT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== tb/kls_token_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kls_token_checker: token predictor and scoreboard for the keyword lexer
// Watches both channels, predicts the token results of every accepted
// source item and compares each accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module kls_token_checker import kls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int BUF_IW = $clog2(MAX_TEXT_DEF);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_PLUS   = "+";

    localparam logic [3:0] KIND_FUNC  = KIND_KW_BASE;
    localparam logic [3:0] KIND_TRUE  = KIND_KW_BASE + 4'd1;
    localparam logic [3:0] KIND_FALSE = KIND_KW_BASE + 4'd2;
    localparam logic [3:0] KIND_AND   = KIND_KW_BASE + 4'd3;
    localparam logic [3:0] KIND_OR    = KIND_KW_BASE + 4'd4;
    localparam logic [3:0] KIND_NOT   = KIND_KW_BASE + 4'd5;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_WORD,
        LX_STRING,
        LX_COMMENT,
        LX_HALTED
    } t_lex_mode;

    t_lex_mode   lex_state;
    logic [7:0]  word_buf [MAX_TEXT_DEF];
    int          buf_len;
    logic [15:0] tok_count;
    t_out        step_results [$];
    t_out        expected_tokens [$];
    int          mismatches = 0;

    task automatic count_token();
        if (tok_count != 16'hFFFF) begin
            tok_count = tok_count + 16'd1;
        end
    endtask

    task automatic add_result(input logic [3:0] kind, input logic [7:0] ch,
                              input logic cv, input logic te);
        t_out r;
        r.token_kind    = kind;
        r.text_char     = ch;
        r.char_valid    = cv;
        r.token_end     = te;
        r.tokens_so_far = tok_count;
        r.last          = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic single_token(input logic [3:0] kind);
        count_token();
        add_result(kind, 8'h00, 1'b0, 1'b1);
    endtask

    task automatic raise_error();
        single_token(KIND_ERROR);
        lex_state = LX_HALTED;
    endtask

    // Text tokens put out one character per result; an empty one still
    // takes a single result without a character.
    task automatic emit_text(input logic [3:0] kind);
        int i;
        count_token();
        if (buf_len == 0) begin
            add_result(kind, 8'h00, 1'b0, 1'b1);
        end else begin
            for (i = 0; i < buf_len; i++) begin
                add_result(kind, word_buf[BUF_IW'(i)], 1'b1, i == buf_len - 1);
            end
        end
    endtask

    // Exact keyword match; anything else is an identifier.
    function automatic logic [3:0] word_kind();
        logic [39:0] word_bits;
        int          i;
        word_bits = '0;
        if (buf_len > 5) begin
            return KIND_IDENT;
        end
        for (i = 0; i < buf_len; i++) begin
            word_bits = {word_bits[31:0], word_buf[BUF_IW'(i)]};
        end
        case (buf_len)
            2: if (word_bits[15:0] == "or") return KIND_OR;
            3: begin
                if (word_bits[23:0] == "and") return KIND_AND;
                if (word_bits[23:0] == "not") return KIND_NOT;
            end
            4: begin
                if (word_bits[31:0] == "func") return KIND_FUNC;
                if (word_bits[31:0] == "true") return KIND_TRUE;
            end
            5: if (word_bits == "false") return KIND_FALSE;
            default: ;
        endcase
        return KIND_IDENT;
    endfunction

    task automatic flush_word();
        logic [3:0] kind;
        kind = word_kind();
        if (kind == KIND_IDENT) begin
            emit_text(KIND_IDENT);
        end else begin
            single_token(kind);
        end
    endtask

    task automatic append_byte(input logic [7:0] c);
        if (buf_len < MAX_TEXT_DEF) begin
            word_buf[BUF_IW'(buf_len)] = c;
            buf_len++;
        end else begin
            raise_error();
        end
    endtask

    task automatic idle_byte(input logic [7:0] c);
        case (c)
            CH_LPAREN: single_token(KIND_LPAREN);
            CH_RPAREN: single_token(KIND_RPAREN);
            CH_LBRACE: single_token(KIND_LBRACE);
            CH_RBRACE: single_token(KIND_RBRACE);
            CH_PLUS:   single_token(KIND_PLUS);
            CH_QUOTE: begin
                lex_state = LX_STRING;
                buf_len   = 0;
            end
            CH_SLASH: lex_state = LX_COMMENT;
            CH_SPACE, CH_LF, CH_TAB, CH_CR: ;
            default: begin
                if (c >= "a" && c <= "z") begin
                    lex_state   = LX_WORD;
                    word_buf[0] = c;
                    buf_len     = 1;
                end else begin
                    raise_error();
                end
            end
        endcase
    endtask

    task automatic lex_item(input t_in item);
        t_out       r;
        logic [7:0] c;
        c = item.char_code;
        step_results.delete();
        if (item.end_of_text) begin
            if (lex_state == LX_WORD) begin
                flush_word();
            end else if (lex_state == LX_STRING) begin
                raise_error();
            end
            lex_state = LX_IDLE;
            buf_len   = 0;
            tok_count = '0;
        end else begin
            case (lex_state)
                LX_HALTED: ;
                LX_COMMENT: if (c == CH_LF) lex_state = LX_IDLE;
                LX_STRING: begin
                    if (c == CH_QUOTE) begin
                        emit_text(KIND_STRING);
                        lex_state = LX_IDLE;
                        buf_len   = 0;
                    end else begin
                        append_byte(c);
                    end
                end
                LX_WORD: begin
                    if (c >= "a" && c <= "z") begin
                        append_byte(c);
                    end else begin
                        // The word goes out first, then the byte that ended it.
                        flush_word();
                        lex_state = LX_IDLE;
                        buf_len   = 0;
                        idle_byte(c);
                    end
                end
                default: idle_byte(c);
            endcase
        end
        if (step_results.size() > 0) begin
            r      = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
        end
        foreach (step_results[i]) begin
            expected_tokens.push_back(step_results[i]);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (expected_tokens.size() == 0) begin
            $error("token result with nothing expected: kind %0d", got.token_kind);
            mismatches++;
        end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
            check_field("text_char", 32'(want.text_char), 32'(got.text_char));
            check_field("char_valid", 32'(want.char_valid), 32'(got.char_valid));
            check_field("token_end", 32'(want.token_end), 32'(got.token_end));
            check_field("tokens_so_far", 32'(want.tokens_so_far),
                        32'(got.tokens_so_far));
            check_field("last", 32'(want.last), 32'(got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lex_state = LX_IDLE;
            buf_len   = 0;
            tok_count = '0;
            expected_tokens.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                lex_item(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_data);
            end
        end
        o_pending    = expected_tokens.size();
        o_fail_count = mismatches;
    end

endmodule

// ===== tb/tb_keyword_lexer_stream.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_keyword_lexer_stream: testbench of the streaming keyword lexer
// Feeds source bytes and end-of-text items through the input channel under
// several idle and stall patterns; the token checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_keyword_lexer_stream;
    import kls_pkg::*;

    // Longest run of cycles without any accepted item before giving up.
    // The longest legitimate quiet stretch is the deliberate receiver hold.
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int HOLD_CYCLES      = 120;
    localparam int PHASE_ITEMS      = 36;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    int fail_count;
    int pending_count;

    // Idle and stall rates in percent, changed between stimulus phases.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_request       = 1'b0;
    int offered            = 0;
    int quiet_cycles       = 0;

    string punct    = "(){}+";
    string blanks   = " \t\015\n";
    string keywords [6] = '{"func", "true", "false", "and", "or", "not"};

    always #6 clk = ~clk;

    keyword_lexer_stream u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    kls_token_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Watchdog: a hung handshake on either side shows up as a long run of
    // cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("keyword_lexer_stream test failed");
            $finish;
        end
    end

    // Receiver. Stall is redrawn at every falling edge from the current
    // rate. On request it holds off once for a long stretch so that the
    // lexer backs up and stalls its input while the sender keeps offering.
    initial begin
        int held;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request && !hold_done) begin
                out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(negedge clk);
                end
                hold_done = 1'b1;
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Offers one item. Idle gaps are inserted before it at the current rate;
    // once valid is raised the payload stays put until the item is taken.
    task automatic send_item(input t_in item);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(posedge clk);
        end while (in_stall);
        offered++;
    endtask

    task automatic send_char(input logic [7:0] c);
        t_in item;
        item.char_code   = c;
        item.end_of_text = 1'b0;
        send_item(item);
    endtask

    // End of text; the byte rides along and must be ignored.
    task automatic send_end(input logic [7:0] c);
        t_in item;
        item.char_code   = c;
        item.end_of_text = 1'b1;
        send_item(item);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    // Up to three random bytes after a halt; the lexer drops them, so they are not
    // counted as stimulus.
    task automatic send_halt_noise();
        repeat ($urandom_range(3)) begin
            send_char(8'($urandom));
            offered--;
        end
    endtask

    function automatic logic [7:0] random_letter();
        return 8'("a" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] random_except(input logic [7:0] banned);
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (c == banned);
        return c;
    endfunction

    // A byte that starts no token at all: it must give an error.
    function automatic logic [7:0] random_unknown();
        logic [7:0] c;
        bit         known;
        int         i;
        do begin
            c     = 8'($urandom);
            known = (c >= "a" && c <= "z") || c == "\"" || c == "/";
            for (i = 0; i < punct.len(); i++) begin
                known |= (c == punct[i]);
            end
            for (i = 0; i < blanks.len(); i++) begin
                known |= (c == blanks[i]);
            end
        end while (known);
        return c;
    endfunction

    // Something that ends a word: punctuation, blank space, or now and then
    // the end of the text itself.
    task automatic send_delimiter();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) begin
            send_end(8'($urandom));
        end else if (pick < 4) begin
            send_char(punct[$urandom_range(4)]);
        end else begin
            send_char(blanks[$urandom_range(3)]);
        end
    endtask

    // Random source text. Most of it is well-formed tokens with random
    // content, so the word, string and comment modes are exercised in depth;
    // the rest is overlong text, unknown bytes, unterminated strings and
    // stray end-of-text items. Every error is followed by end of text, since
    // a halted lexer ignores everything else.
    task automatic random_phase(input int target);
        int    stop;
        int    pick;
        int    n;
        string kw;
        stop = offered + target;
        while (offered < stop) begin
            pick = $urandom_range(99);
            if (pick < 14) begin
                send_char(punct[$urandom_range(4)]);
            end else if (pick < 22) begin
                send_char(blanks[$urandom_range(3)]);
            end else if (pick < 40) begin
                // Keywords, plus near misses one letter too long or too short.
                kw = keywords[3'($urandom_range(5))];
                case ($urandom_range(3))
                    2: begin
                        send_text(kw);
                        send_char(random_letter());
                    end
                    3: send_text(kw.substr(0, kw.len() - 2));
                    default: send_text(kw);
                endcase
                send_delimiter();
            end else if (pick < 56) begin
                // Identifiers, mostly short, sometimes up to the buffer size.
                n = ($urandom_range(7) == 0) ? $urandom_range(14, 16) : $urandom_range(1, 6);
                repeat (n) send_char(random_letter());
                send_delimiter();
            end else if (pick < 70) begin
                // Strings with arbitrary bytes, empty and full ones included.
                n = ($urandom_range(7) == 0) ? MAX_TEXT_DEF : $urandom_range(0, 8);
                send_char("\"");
                repeat (n) send_char(random_except("\""));
                send_char("\"");
            end else if (pick < 77) begin
                send_char("/");
                repeat ($urandom_range(5)) send_char(random_except("\n"));
                send_char("\n");
            end else if (pick < 81) begin
                // A word one or more letters over the buffer size.
                repeat ($urandom_range(17, 19)) send_char(random_letter());
                send_halt_noise();
                send_end(8'($urandom));
            end else if (pick < 84) begin
                send_char("\"");
                repeat (MAX_TEXT_DEF + 1) send_char(random_except("\""));
                send_halt_noise();
                send_end(8'($urandom));
            end else if (pick < 88) begin
                send_char(random_unknown());
                send_halt_noise();
                send_end(8'($urandom));
            end else if (pick < 92) begin
                // A string still open at the end of the text is an error.
                send_char("\"");
                repeat ($urandom_range(4)) send_char(random_except("\""));
                send_end(8'($urandom));
            end else begin
                send_end(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: every punctuation token, every blank, an empty and
        // a one-character string, a comment, a keyword ended by punctuation,
        // a word flushed by end of text, and a halt on a NUL byte with a
        // byte ignored behind it.
        send_text("(){}+");
        send_text(" \t\015\n");
        send_text("\"\"");
        send_text("\"a\"");
        send_text("/\n");
        send_text("or(");
        send_text("ab");
        send_end(8'hFF);
        send_char(8'h00);
        send_char(8'hFF);
        send_end(8'h00);

        // No idling at first, but with the long receiver hold at its start.
        hold_request = 1'b1;
        random_phase(PHASE_ITEMS);

        sender_idle_pct    = 67;
        receiver_stall_pct = 0;
        random_phase(PHASE_ITEMS);

        sender_idle_pct    = 0;
        receiver_stall_pct = 67;
        random_phase(PHASE_ITEMS);

        sender_idle_pct    = 20;
        receiver_stall_pct = 20;
        random_phase(PHASE_ITEMS);

        @(negedge clk);
        in_valid <= 1'b0;

        // All results in, then a drain wait to catch anything extra.
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("keyword_lexer_stream test passed");
        end else begin
            $display("keyword_lexer_stream test failed");
        end
        $finish;
    end

endmodule
